// ----- design/hpvd_pkg.sv -----
package hpvd_pkg;

  localparam int DELTA_BITS = 16;
  localparam logic [DELTA_BITS-1:0] DELTA_RESET = 16'd1024;

  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;

  // register index, taken from the word address
  localparam logic REG_DELTA = 1'b0;

  localparam int MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_RISING    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FALLING   = 2'd2;

  localparam logic KIND_PEAK   = 1'b0;
  localparam logic KIND_VALLEY = 1'b1;

endpackage

// ----- design/hpvd_cfg.sv -----
module hpvd_cfg
  import hpvd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  output logic [DELTA_BITS-1:0] delta
);

  logic [DELTA_BITS-1:0] delta_r;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RESET;
    end else if (wr_en && (paddr[2] == REG_DELTA)) begin
      delta_r <= pwdata[DELTA_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_DELTA: prdata = DATA_BITS'(delta_r);
      default:   prdata = '0;
    endcase
  end

  assign delta = delta_r;

endmodule

// ----- design/hpvd_track.sv -----
module hpvd_track
  import hpvd_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SAMPLE_BITS-1:0]   delta,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  logic                     in_start_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POSITION_BITS-1:0] out_position,
  output logic [SAMPLE_BITS-1:0]   out_value,
  output logic                     out_kind
);

  // input register
  logic                     s1_v_r;
  logic [SAMPLE_BITS-1:0]   s1_sample_r;
  logic                     s1_start_r;

  // tracker state
  logic [MODE_BITS-1:0]     mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] max_pos_r, max_pos_nxt;
  logic [SAMPLE_BITS-1:0]   max_val_r, max_val_nxt;
  logic [POSITION_BITS-1:0] min_pos_r, min_pos_nxt;
  logic [SAMPLE_BITS-1:0]   min_val_r, min_val_nxt;
  logic [POSITION_BITS-1:0] cnt_r, cnt_nxt;

  // result register
  logic                     ov_r;
  logic [POSITION_BITS-1:0] opos_r;
  logic [SAMPLE_BITS-1:0]   oval_r;
  logic                     okind_r;

  logic                     first;
  logic [POSITION_BITS-1:0] pos;
  logic [MODE_BITS-1:0]     mode_e;
  logic [POSITION_BITS-1:0] mx_pos, mn_pos;
  logic [SAMPLE_BITS-1:0]   mx_val, mn_val;
  logic [SAMPLE_BITS:0]     s_ext, e_ext;
  logic                     fall_hit, rise_hit;
  logic                     fire;
  logic                     ev_kind;
  logic [POSITION_BITS-1:0] ev_pos;
  logic [SAMPLE_BITS-1:0]   ev_val;
  logic                     out_free, adv;

  // first word of a series loads both extremes with this sample
  assign first  = s1_start_r || (cnt_r == '0);
  assign pos    = first ? '0 : cnt_r;
  assign mode_e = first ? MODE_UNDECIDED : mode_r;
  assign mx_pos = first ? '0 : max_pos_r;
  assign mx_val = first ? s1_sample_r : max_val_r;
  assign mn_pos = first ? '0 : min_pos_r;
  assign mn_val = first ? s1_sample_r : min_val_r;

  // one extra bit so that sample plus delta never wraps
  assign s_ext    = {1'b0, s1_sample_r};
  assign e_ext    = {1'b0, delta};
  assign fall_hit = {1'b0, mx_val} >= (s_ext + e_ext);
  assign rise_hit = s_ext >= ({1'b0, mn_val} + e_ext);

  always_comb begin
    mode_nxt    = mode_e;
    max_pos_nxt = mx_pos;
    max_val_nxt = mx_val;
    min_pos_nxt = mn_pos;
    min_val_nxt = mn_val;
    fire        = 1'b0;
    ev_kind     = KIND_PEAK;
    ev_pos      = mx_pos;
    ev_val      = mx_val;
    unique case (mode_e)
      MODE_RISING: begin
        if (mx_val <= s1_sample_r) begin
          max_pos_nxt = pos;
          max_val_nxt = s1_sample_r;
        end else if (fall_hit) begin
          fire        = 1'b1;
          ev_kind     = KIND_PEAK;
          ev_pos      = mx_pos;
          ev_val      = mx_val;
          min_pos_nxt = pos;
          min_val_nxt = s1_sample_r;
          mode_nxt    = MODE_FALLING;
        end
      end
      MODE_FALLING: begin
        if (s1_sample_r <= mn_val) begin
          min_pos_nxt = pos;
          min_val_nxt = s1_sample_r;
        end else if (rise_hit) begin
          fire        = 1'b1;
          ev_kind     = KIND_VALLEY;
          ev_pos      = mn_pos;
          ev_val      = mn_val;
          max_pos_nxt = pos;
          max_val_nxt = s1_sample_r;
          mode_nxt    = MODE_RISING;
        end
      end
      default: begin
        // undecided, and the unused code
        if (fall_hit) begin
          mode_nxt = MODE_FALLING;
        end else if (rise_hit) begin
          mode_nxt = MODE_RISING;
        end
        if (mx_val <= s1_sample_r) begin
          max_pos_nxt = pos;
          max_val_nxt = s1_sample_r;
        end else if (s1_sample_r <= mn_val) begin
          min_pos_nxt = pos;
          min_val_nxt = s1_sample_r;
        end
      end
    endcase
  end

  // position saturates at all ones
  assign cnt_nxt = (pos != '1) ? pos + 1'b1 : pos;

  assign out_free = !ov_r || !out_stall;
  assign adv      = s1_v_r && (!fire || out_free);
  assign in_stall = s1_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_r <= in_sample;
      s1_start_r  <= in_start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_UNDECIDED;
      max_pos_r <= '0;
      max_val_r <= '0;
      min_pos_r <= '0;
      min_val_r <= '0;
      cnt_r     <= '0;
    end else if (adv) begin
      mode_r    <= mode_nxt;
      max_pos_r <= max_pos_nxt;
      max_val_r <= max_val_nxt;
      min_pos_r <= min_pos_nxt;
      min_val_r <= min_val_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_free) begin
      ov_r <= adv && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fire) begin
      opos_r  <= ev_pos;
      oval_r  <= ev_val;
      okind_r <= ev_kind;
    end
  end

  assign out_valid    = ov_r;
  assign out_position = opos_r;
  assign out_value    = oval_r;
  assign out_kind     = okind_r;

endmodule

// ----- design/hysteresis_peak_valley_detector.sv -----
// channel   ports                                     word accepted when
// in        in_valid in_stall in_sample in_start_req  in_valid && !in_stall
// out       out_valid out_stall out_position ...      out_valid && !out_stall
// cfg       psel penable pwrite paddr pwdata prdata   psel && penable && pwrite
//
// one sample per cycle while in_stall is low; a sample enters the input register,
// is processed from there and any event goes through the result register to out_*
// synchronous active-low reset; delta resets to 1024, tracker to undecided
// the input stalls only when a held event waits on out_stall and the sample
// in the input register would produce another event
module hysteresis_peak_valley_detector
  import hpvd_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [DATA_BITS-1:0]     pwdata,
  output logic [DATA_BITS-1:0]     prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  logic                     in_start_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POSITION_BITS-1:0] out_position,
  output logic [SAMPLE_BITS-1:0]   out_value,
  output logic                     out_kind
);

  localparam int WIDE_BITS = (SAMPLE_BITS > DELTA_BITS) ? SAMPLE_BITS : DELTA_BITS;

  logic [DELTA_BITS-1:0]  delta;
  logic [WIDE_BITS-1:0]   delta_wide;
  logic [SAMPLE_BITS-1:0] delta_s;

  hpvd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delta   (delta)
  );

  // only the low sample bits of delta take part
  assign delta_wide = WIDE_BITS'(delta);
  assign delta_s    = delta_wide[SAMPLE_BITS-1:0];

  hpvd_track #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .delta        (delta_s),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_value    (out_value),
    .out_kind     (out_kind)
  );

endmodule
